@@ hdl/kmq_pkg.sv @@
// ----------------------------------------------------------------------------
// kmq_pkg: shared types and constants of the keyed message queue
// Queue depth, field widths, operation codes and the control and entry
// structures that the top level hands to every cell.
// ----------------------------------------------------------------------------
package kmq_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned IdW     = 16;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CountW  = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CHECK  = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_POP    = 2'd3
  } kind_e;

  // One stored entry.
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [HandleW-1:0] handle;
  } entry_t;

  // Operation broadcast to every cell in the accepting cycle.
  typedef struct packed {
    logic               en;
    kind_e              kind;
    logic [IdW-1:0]     key;
    logic [HandleW-1:0] handle;
  } ctrl_t;

endpackage

@@ hdl/kmq_cell.sv @@
// ----------------------------------------------------------------------------
// kmq_cell: one slot of the keyed message queue
// Holds one entry and its occupied flag, compares its id with the key, takes
// part in the oldest-match chain and shifts in its upper neighbour's entry
// when a removal at or below it closes the gap.
// ----------------------------------------------------------------------------
module kmq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kmq_pkg::ctrl_t  ctrl_i,
  input  logic            prev_occ_i,   // occupied flag of the older neighbour
  input  logic            next_occ_i,   // occupied flag of the younger neighbour
  input  kmq_pkg::entry_t next_entry_i, // entry of the younger neighbour
  input  logic            hit_i,        // an older cell has already matched
  input  kmq_pkg::entry_t take_i,       // removed entry gathered so far
  output logic            occ_o,
  output kmq_pkg::entry_t entry_o,
  output logic            hit_o,
  output kmq_pkg::entry_t take_o
);

  logic            occ_q, occ_d;
  kmq_pkg::entry_t entry_q, entry_d;
  logic            match;
  logic            first;
  logic            removing;

  // A pop treats every occupied cell as a match, so the oldest one goes.
  always_comb begin
    if (ctrl_i.kind == kmq_pkg::KIND_POP) begin
      match = occ_q;
    end else begin
      match = occ_q && (entry_q.id == ctrl_i.key);
    end
  end

  assign first    = match && !hit_i;
  assign hit_o    = hit_i || match;
  assign take_o   = first ? (take_i | entry_q) : take_i;
  assign removing = ctrl_i.en && hit_o &&
                    ((ctrl_i.kind == kmq_pkg::KIND_REMOVE) ||
                     (ctrl_i.kind == kmq_pkg::KIND_POP));

  always_comb begin
    occ_d   = occ_q;
    entry_d = entry_q;
    if (removing) begin
      occ_d   = next_occ_i;
      entry_d = next_entry_i;
    end else if (ctrl_i.en && (ctrl_i.kind == kmq_pkg::KIND_APPEND) &&
                 prev_occ_i && !occ_q) begin
      occ_d          = 1'b1;
      entry_d.id     = ctrl_i.key;
      entry_d.handle = ctrl_i.handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign occ_o   = occ_q;
  assign entry_o = entry_q;

endmodule

@@ hdl/keyed_message_queue.sv @@
// ----------------------------------------------------------------------------
// keyed_message_queue: ordered message queue with removal by id
// Output: the result of a transfer is registered and offered in the cycle after it is taken.
// Throughput: one operation per cycle; the single result register is the
// only stage, and a new transfer is taken whenever it is free or being read.
// Reset: rst_ni clears the occupied flags, the entry count and the result
// valid flag; stored ids and handles are not reset.
// ----------------------------------------------------------------------------
module keyed_message_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [15:0] msg_id, [31:16] payload
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // [0] found, [1] full_reject, [17:2] out_id,
                                       // [33:18] out_payload, [38:34] entry_count,
                                       // [39] zero
);

  localparam int unsigned N = kmq_pkg::Depth;

  // The queue is a row of cells, oldest entry in cell 0. Every cell sees the
  // operation at once; the hit chain runs from the oldest cell upwards so
  // that only the oldest match is removed, and the cells from that point on
  // take their younger neighbour's entry, closing the gap in the same cycle.

  kmq_pkg::ctrl_t  ctrl;
  logic            in_fire;
  logic            out_fire;

  logic            occ   [N];
  kmq_pkg::entry_t entry [N];
  logic            hit   [N+1];
  kmq_pkg::entry_t take  [N+1];
  logic [N-1:0]    occ_vec;

  logic [kmq_pkg::CountW-1:0] count_q, count_d;
  logic                       full;
  logic                       any_hit;

  logic                       out_valid_q;
  logic                       found_d, found_q;
  logic                       reject_d, reject_q;
  kmq_pkg::entry_t            res_d, res_q;
  logic [kmq_pkg::CountW-1:0] res_count_q;

  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign ctrl.en     = in_fire;
  assign ctrl.kind   = kmq_pkg::kind_e'(s_axis_tuser_i);
  assign ctrl.key    = s_axis_tdata_i[kmq_pkg::IdW-1:0];
  assign ctrl.handle = s_axis_tdata_i[kmq_pkg::IdW +: kmq_pkg::HandleW];

  assign hit[0]  = 1'b0;
  assign take[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            prev_occ;
    logic            next_occ;
    kmq_pkg::entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ[i-1];
    end

    // The youngest cell shifts in an empty slot.
    if (i == N - 1) begin : g_last
      assign next_occ   = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_occ   = occ[i+1];
      assign next_entry = entry[i+1];
    end

    kmq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_occ_i   (prev_occ),
      .next_occ_i   (next_occ),
      .next_entry_i (next_entry),
      .hit_i        (hit[i]),
      .take_i       (take[i]),
      .occ_o        (occ[i]),
      .entry_o      (entry[i]),
      .hit_o        (hit[i+1]),
      .take_o       (take[i+1])
    );

    assign occ_vec[i] = occ[i];
  end

  assign full    = (count_q == kmq_pkg::CountW'(N));
  assign any_hit = hit[N];

  // Result and new entry count for the operation presented this cycle.
  always_comb begin
    found_d  = 1'b0;
    reject_d = 1'b0;
    res_d    = '0;
    count_d  = count_q;
    case (ctrl.kind)
      kmq_pkg::KIND_APPEND: begin
        if (full) begin
          reject_d = 1'b1;
        end else begin
          found_d = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      kmq_pkg::KIND_CHECK: begin
        found_d = any_hit;
      end
      kmq_pkg::KIND_REMOVE, kmq_pkg::KIND_POP: begin
        found_d = any_hit;
        if (any_hit) begin
          res_d   = take[N];
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        found_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload is only meaningful while out_valid_q is set.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      found_q     <= found_d;
      reject_q    <= reject_d;
      res_q       <= res_d;
      res_count_q <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_count_q, res_q.handle, res_q.id, reject_q, found_q};

`ifndef ASSERT_OFF
  // The count always agrees with the number of occupied cells.
  a_count_matches_cells: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == 32'(count_q)
  ) else $error("entry count disagrees with occupied cells");

  // Occupied cells always form an unbroken run from the oldest cell.
  a_cells_packed: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $onehot0(occ_vec + 1'b1) || (occ_vec == '1)
  ) else $error("gap in occupied cells");

  // A refused append is reported only with a full queue, never with found.
  a_reject_only_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && reject_q) |-> (!found_q && (res_count_q == kmq_pkg::CountW'(N)))
  ) else $error("append refused without a full queue");

  // An accepted append grows the queue by exactly one entry.
  a_append_grows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (ctrl.kind == kmq_pkg::KIND_APPEND) && !full) |=>
      (count_q == $past(count_q) + 1'b1)
  ) else $error("accepted append did not add one entry");
`endif

endmodule
